### rtl/core/bop_pkg.sv
`default_nettype none
package bop_pkg;

  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned EXP_TERMS     = 24;

  localparam logic [63:0] ONE28 = 64'h0000_0000_1000_0000;
  localparam logic [63:0] ONE30 = 64'h0000_0000_4000_0000;
  localparam logic [63:0] M32   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] X_CAP = 64'h0000_0000_C000_0000;
  localparam logic [63:0] H_CAP = 64'h0000_0003_FFFF_FFFF;

  typedef enum logic [2:0] {
    CFG_STRIKE,
    CFG_EXPIRY,
    CFG_VOLATILITY,
    CFG_RATE,
    CFG_MIN_PERIODS,
    CFG_MODE,
    CFG_DIVIDEND_A,
    CFG_DIVIDEND_B
  } cfg_index_t;

  typedef enum logic {
    DOP_DIV,
    DOP_SQRT
  } div_op_t;

  typedef struct packed {
    logic    start;
    div_op_t op;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NDIV,
    ST_NMUL,
    ST_HDIV,
    ST_SQRT,
    ST_XMUL,
    ST_EMUL,
    ST_EDIV,
    ST_DDIV,
    ST_RMUL1,
    ST_RMUL2,
    ST_PCHK,
    ST_PDIV,
    ST_PWR_U,
    ST_PWR_D,
    ST_NP_RD,
    ST_NP_MUL1,
    ST_NP_MUL2,
    ST_LVL_MUL,
    ST_LVL_DIV,
    ST_ND_RD1,
    ST_ND_RD2,
    ST_ND_RD3,
    ST_ND_MUL1,
    ST_ND_MUL2,
    ST_ND_DIV,
    ST_OUT_RD,
    ST_OUT_CAP
  } state_t;

endpackage
`default_nettype wire

### rtl/core/bop_mul.sv
`default_nettype none
module bop_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic [127:0]  prod,
  output logic          done
);
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  pp;
  logic [2:0]   cnt;
  logic         active;
  logic [127:0] acc;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [1:0]   prev;
  logic [127:0] pp_shift;

  // 64x64 product from four 32x32 partials, one per cycle
  always_comb begin
    a_half = cnt[1] ? a_r[63:32] : a_r[31:0];
    b_half = cnt[0] ? b_r[63:32] : b_r[31:0];
    prev   = 2'(cnt - 3'd1);
    unique case (prev)
      2'd0:    pp_shift = {64'd0, pp};
      2'd1:    pp_shift = {32'd0, pp, 32'd0};
      2'd2:    pp_shift = {32'd0, pp, 32'd0};
      default: pp_shift = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc    <= '0;
        cnt    <= '0;
        active <= 1'b1;
      end else if (active) begin
        if (cnt != 3'd4) pp <= a_half * b_half;
        if (cnt != 3'd0) acc <= acc + pp_shift;
        if (cnt == 3'd4) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

  assign prod = acc;

endmodule
`default_nettype wire

### rtl/core/bop_div.sv
`default_nettype none
module bop_div (
  input  logic              clk,
  input  logic              rst,
  input  bop_pkg::div_req_t req,
  input  logic [63:0]       num,
  input  logic [63:0]       den,
  output logic [63:0]       quo,
  output logic              done
);
  import bop_pkg::*;

  logic [63:0] rem;
  logic [63:0] acc;
  logic [63:0] den_r;
  logic [63:0] bitv;
  logic [5:0]  cnt;
  logic        active;
  div_op_t     op_r;
  logic [64:0] rsh;
  logic [64:0] rdiff;
  logic        rge;
  logic [63:0] ssum;
  logic        sge;
  logic        last;

  // restoring divide, one quotient bit a cycle; bitwise root, one result bit a cycle
  always_comb begin
    rsh   = {rem, acc[63]};
    rdiff = rsh - {1'b0, den_r};
    rge   = rsh >= {1'b0, den_r};
    ssum  = acc + bitv;
    sge   = rem >= ssum;
    last  = (op_r == DOP_SQRT) ? (cnt == 6'd31) : (cnt == 6'd63);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
      op_r   <= DOP_DIV;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        op_r   <= req.op;
        cnt    <= '0;
        active <= 1'b1;
        den_r  <= den;
        if (req.op == DOP_SQRT) begin
          rem  <= num;
          acc  <= '0;
          bitv <= 64'h4000_0000_0000_0000;
        end else begin
          rem <= '0;
          acc <= num;
        end
      end else if (active) begin
        if (op_r == DOP_SQRT) begin
          if (sge) begin
            rem <= rem - ssum;
            acc <= (acc >> 1) + bitv;
          end else begin
            acc <= acc >> 1;
          end
          bitv <= bitv >> 2;
        end else begin
          if (rge) begin
            rem <= rdiff[63:0];
            acc <= {acc[62:0], 1'b1};
          end else begin
            rem <= rsh[63:0];
            acc <= {acc[62:0], 1'b0};
          end
        end
        if (last) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
        cnt <= cnt + 6'd1;
      end
    end
  end

  assign quo = acc;

endmodule
`default_nettype wire

### rtl/core/binomial_option_pricer_core.sv
// An expired date answers in the cycle after start.
// Throughput: one request at a time; busy stays high until the result strobe.
// The result is shown for one cycle with done; the receiver cannot stall.
// Reset: synchronous; clears control and configuration but sets mode to 1; node store and power tables left undefined.
`default_nettype none
module binomial_option_pricer_core #(
  parameter int unsigned MAX_STEPS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] share_price,
  input  logic [21:0] today,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output logic [31:0] option_value,
  output logic [10:0] periods_used,
  output logic        date_error
);
  import bop_pkg::*;

  localparam int unsigned AW = $clog2(MAX_STEPS + 1);

  // configuration
  logic [31:0] strike;
  logic [21:0] expiry_day;
  logic [31:0] volatility;
  logic [31:0] rate;
  logic [10:0] min_periods;
  logic [1:0]  mode;
  logic [63:0] dividend_a;
  logic [63:0] dividend_b;

  // sequencer
  state_t state;
  state_t state_next;
  logic   issued;
  logic   mul_go;
  logic   div_go;
  logic   mul_start;
  div_req_t div_req;
  div_op_t  div_op;
  logic   op_done;

  // shared units
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic [127:0] mul_prod;
  logic         mul_done;
  logic [63:0]  div_num;
  logic [63:0]  div_den;
  logic [63:0]  div_quo;
  logic         div_done;

  // working registers
  logic [31:0]    s_reg;
  logic [21:0]    today_reg;
  logic [21:0]    dt;
  logic [AW-1:0]  n;
  logic [63:0]    q;
  logic [63:0]    h;
  logic [32:0]    sq;
  logic [29:0]    xq;
  logic [63:0]    acc;
  logic [4:0]     kcnt;
  logic [31:0]    up_factor;
  logic [31:0]    d;
  logic [63:0]    rh1;
  logic [31:0]    growth_factor;
  logic [30:0]    up_probability;
  logic [63:0]    upow_cur;
  logic [63:0]    dpow_cur;
  logic [AW-1:0]  icnt;
  logic [AW-1:0]  jcnt;
  logic           leaf;
  logic [31:0]    base;
  logic [31:0]    vup;
  logic [31:0]    vdn;
  logic [63:0]    t;
  logic [63:0]    a1;
  logic [63:0]    v;

  // memories
  logic [31:0]    node_mem [0:MAX_STEPS];
  logic [63:0]    upow_mem [0:MAX_STEPS];
  logic [63:0]    dpow_mem [0:MAX_STEPS];
  logic           node_we;
  logic [AW-1:0]  node_waddr;
  logic [31:0]    node_wdata;
  logic [AW-1:0]  node_raddr;
  logic [31:0]    node_rd;
  logic           tab_we;
  logic [AW-1:0]  tab_waddr;
  logic [63:0]    upow_wdata;
  logic [63:0]    dpow_wdata;
  logic [AW-1:0]  up_raddr;
  logic [AW-1:0]  dn_raddr;
  logic [63:0]    upow_rd;
  logic [63:0]    dpow_rd;

  // combinational helpers
  logic           expired;
  logic [21:0]    dt_in;
  logic [AW+8:0]  days_n;
  logic [63:0]    hs;
  logic [33:0]    x_raw;
  logic [33:0]    x_clip;
  logic [63:0]    acc_new;
  logic [63:0]    rr_full;
  logic [32:0]    dv;
  logic [32:0]    dvx;
  logic [22:0]    xday;
  logic [31:0]    price;
  logic [31:0]    leaf_price;
  logic [31:0]    ex;
  logic [63:0]    vmax;
  logic           last_j;

  function automatic logic [AW-1:0] cap_steps(input logic [63:0] val);
    if (val > 64'(MAX_STEPS)) return AW'(MAX_STEPS);
    return val[AW-1:0];
  endfunction

  function automatic logic [63:0] sat28_64(input logic [127:0] pr);
    if (pr[127:92] != '0) return '1;
    return pr[91:28];
  endfunction

  function automatic logic [31:0] sat28_32(input logic [127:0] pr);
    if (pr[127:92] != '0) return '1;
    if (pr[91:28] > M32) return '1;
    return pr[59:28];
  endfunction

  function automatic logic [32:0] dividend_sum(input logic [21:0] day0,
                                               input logic [22:0] limit,
                                               input logic [63:0] da,
                                               input logic [63:0] db);
    logic [32:0] sum;
    sum = '0;
    if ({10'd0, day0} < da[63:32] && {9'd0, limit} > da[63:32]) sum = sum + 33'(da[31:0]);
    if ({10'd0, day0} < db[63:32] && {9'd0, limit} > db[63:32]) sum = sum + 33'(db[31:0]);
    return sum;
  endfunction

  function automatic logic [31:0] exercise(input logic [31:0] pr, input logic [31:0] k,
                                           input logic call);
    if (call) return (pr > k) ? pr - k : '0;
    return (k > pr) ? k - pr : '0;
  endfunction

  bop_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  bop_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .done (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strike      <= '0;
      expiry_day  <= '0;
      volatility  <= '0;
      rate        <= '0;
      min_periods <= '0;
      mode        <= 2'd1;
      dividend_a  <= '0;
      dividend_b  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_STRIKE:      strike      <= cfg_data[31:0];
        CFG_EXPIRY:      expiry_day  <= cfg_data[21:0];
        CFG_VOLATILITY:  volatility  <= cfg_data[31:0];
        CFG_RATE:        rate        <= cfg_data[31:0];
        CFG_MIN_PERIODS: min_periods <= cfg_data[10:0];
        CFG_MODE:        mode        <= cfg_data[1:0];
        CFG_DIVIDEND_A:  dividend_a  <= cfg_data;
        CFG_DIVIDEND_B:  dividend_b  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rd <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      upow_mem[tab_waddr] <= upow_wdata;
      dpow_mem[tab_waddr] <= dpow_wdata;
    end
    upow_rd <= upow_mem[up_raddr];
    dpow_rd <= dpow_mem[dn_raddr];
  end

  always_comb begin
    expired    = today >= expiry_day;
    dt_in      = expiry_day - today;
    days_n     = (AW+9)'(DAYS_PER_YEAR) * (AW+9)'(n);
    hs         = (h > H_CAP) ? H_CAP : h;
    x_raw      = mul_prod[63:30];
    x_clip     = (x_raw > X_CAP[33:0]) ? X_CAP[33:0] : x_raw;
    acc_new    = ONE28 + div_quo;
    rr_full    = ONE28 + ((rh1 + {30'd0, mul_prod[63:30]}) >> 2);
    dv         = dividend_sum(today_reg, 23'(expiry_day), dividend_a, dividend_b);
    xday       = 23'(today_reg) + 23'(div_quo[21:0]);
    dvx        = dividend_sum(today_reg, xday, dividend_a, dividend_b);
    price      = sat28_32(mul_prod);
    leaf_price = (33'(price) > dv) ? 32'(33'(price) - dv) : '0;
    ex         = exercise(price, strike, mode[0]);
    vmax       = (v < 64'(ex)) ? 64'(ex) : v;
    last_j     = jcnt == AW'(icnt - 1'b1);
    up_raddr   = leaf ? icnt : jcnt;
    dn_raddr   = leaf ? AW'(n - icnt) : AW'(icnt - 1'b1 - jcnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= (issued | mul_start | div_req.start) & ~op_done;
    end
  end

  always_comb begin
    state_next = state;
    mul_go     = 1'b0;
    div_go     = 1'b0;
    div_op     = DOP_DIV;
    mul_a      = '0;
    mul_b      = '0;
    div_num    = '0;
    div_den    = 64'd1;
    node_we    = 1'b0;
    node_waddr = jcnt;
    node_wdata = '0;
    node_raddr = jcnt;
    tab_we     = 1'b0;
    tab_waddr  = icnt;
    upow_wdata = upow_cur;
    dpow_wdata = mul_prod[91:28];
    op_done    = mul_done | div_done;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (expired)                state_next = ST_IDLE;
          else if (min_periods != '0) state_next = ST_NDIV;
          else                        state_next = ST_HDIV;
        end
      end
      ST_NDIV: begin
        div_go  = 1'b1;
        div_num = 64'(min_periods) + 64'(dt) - 64'd1;
        div_den = 64'(dt);
        if (op_done) state_next = ST_NMUL;
      end
      ST_NMUL: begin
        mul_go = 1'b1;
        mul_a  = q;
        mul_b  = 64'(dt);
        if (op_done) state_next = ST_HDIV;
      end
      ST_HDIV: begin
        div_go  = 1'b1;
        div_num = 64'({dt, 30'd0});
        div_den = 64'(days_n);
        if (op_done) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        div_go  = 1'b1;
        div_op  = DOP_SQRT;
        div_num = {hs[33:0], 30'd0};
        if (op_done) state_next = ST_XMUL;
      end
      ST_XMUL: begin
        mul_go = 1'b1;
        mul_a  = 64'(volatility);
        mul_b  = 64'(sq);
        if (op_done) state_next = ST_EMUL;
      end
      ST_EMUL: begin
        mul_go = 1'b1;
        mul_a  = acc;
        mul_b  = 64'(xq);
        if (op_done) state_next = ST_EDIV;
      end
      ST_EDIV: begin
        div_go  = 1'b1;
        div_num = t;
        div_den = 64'(kcnt);
        if (op_done) state_next = (kcnt == 5'd1) ? ST_DDIV : ST_EMUL;
      end
      ST_DDIV: begin
        div_go  = 1'b1;
        div_num = 64'd1 << 56;
        div_den = 64'(up_factor);
        if (op_done) state_next = ST_RMUL1;
      end
      ST_RMUL1: begin
        mul_go = 1'b1;
        mul_a  = 64'(rate);
        mul_b  = h >> 30;
        if (op_done) state_next = ST_RMUL2;
      end
      ST_RMUL2: begin
        mul_go = 1'b1;
        mul_a  = 64'(rate);
        mul_b  = 64'(h[29:0]);
        if (op_done) state_next = ST_PCHK;
      end
      ST_PCHK: begin
        tab_we     = 1'b1;
        tab_waddr  = '0;
        upow_wdata = ONE28;
        dpow_wdata = ONE28;
        if (growth_factor <= d || growth_factor >= up_factor) state_next = ST_PWR_U;
        else                                                  state_next = ST_PDIV;
      end
      ST_PDIV: begin
        div_go  = 1'b1;
        div_num = 64'({growth_factor - d, 30'd0});
        div_den = 64'(up_factor - d);
        if (op_done) state_next = ST_PWR_U;
      end
      ST_PWR_U: begin
        mul_go = 1'b1;
        mul_a  = upow_cur;
        mul_b  = 64'(up_factor);
        if (op_done) state_next = ST_PWR_D;
      end
      ST_PWR_D: begin
        mul_go = 1'b1;
        mul_a  = dpow_cur;
        mul_b  = 64'(d);
        if (op_done) begin
          tab_we     = 1'b1;
          state_next = (icnt == n) ? ST_NP_RD : ST_PWR_U;
        end
      end
      ST_NP_RD: state_next = ST_NP_MUL1;
      ST_NP_MUL1: begin
        mul_go = 1'b1;
        mul_a  = leaf ? 64'(s_reg) : 64'(base);
        mul_b  = upow_rd;
        if (op_done) state_next = ST_NP_MUL2;
      end
      ST_NP_MUL2: begin
        mul_go = 1'b1;
        mul_a  = t;
        mul_b  = dpow_rd;
        if (op_done) begin
          node_we = 1'b1;
          if (leaf) begin
            node_waddr = icnt;
            node_wdata = exercise(leaf_price, strike, mode[0]);
            state_next = (icnt == n) ? ST_LVL_MUL : ST_NP_RD;
          end else begin
            node_wdata = (vmax > M32) ? M32[31:0] : vmax[31:0];
            if (!last_j)              state_next = ST_ND_RD1;
            else if (icnt == AW'(1))  state_next = ST_OUT_RD;
            else                      state_next = ST_LVL_MUL;
          end
        end
      end
      ST_LVL_MUL: begin
        mul_go = 1'b1;
        mul_a  = 64'(dt);
        mul_b  = 64'(icnt);
        if (op_done) state_next = ST_LVL_DIV;
      end
      ST_LVL_DIV: begin
        div_go  = 1'b1;
        div_num = q;
        div_den = 64'(n);
        if (op_done) state_next = ST_ND_RD1;
      end
      ST_ND_RD1: begin
        node_raddr = AW'(jcnt + 1'b1);
        state_next = ST_ND_RD2;
      end
      ST_ND_RD2: state_next = ST_ND_RD3;
      ST_ND_RD3: state_next = ST_ND_MUL1;
      ST_ND_MUL1: begin
        mul_go = 1'b1;
        mul_a  = 64'(up_probability);
        mul_b  = 64'(vup);
        if (op_done) state_next = ST_ND_MUL2;
      end
      ST_ND_MUL2: begin
        mul_go = 1'b1;
        mul_a  = 64'(ONE30[30:0] - up_probability);
        mul_b  = 64'(vdn);
        if (op_done) state_next = ST_ND_DIV;
      end
      ST_ND_DIV: begin
        div_go  = 1'b1;
        div_num = t;
        div_den = 64'({growth_factor, 2'b00});
        if (op_done) begin
          if (mode[1]) begin
            state_next = ST_NP_RD;
          end else begin
            node_we    = 1'b1;
            node_wdata = (div_quo > M32) ? M32[31:0] : div_quo[31:0];
            if (!last_j)              state_next = ST_ND_RD1;
            else if (icnt == AW'(1))  state_next = ST_OUT_RD;
            else                      state_next = ST_LVL_MUL;
          end
        end
      end
      ST_OUT_RD: begin
        node_raddr = '0;
        state_next = ST_OUT_CAP;
      end
      ST_OUT_CAP: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
    mul_start     = mul_go & ~issued;
    div_req.start = div_go & ~issued;
    div_req.op    = div_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done           <= 1'b0;
      leaf           <= 1'b0;
      icnt           <= '0;
      jcnt           <= '0;
      kcnt           <= '0;
      up_factor      <= '0;
      growth_factor  <= '0;
      up_probability <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            s_reg     <= share_price;
            today_reg <= today;
            dt        <= dt_in;
            n         <= cap_steps(64'(dt_in));
            if (expired) begin
              option_value <= '0;
              periods_used <= '0;
              date_error   <= 1'b1;
              done         <= 1'b1;
            end
          end
        end
        ST_NDIV:  if (op_done) q <= div_quo;
        ST_NMUL:  if (op_done) n <= cap_steps(mul_prod[63:0]);
        ST_HDIV:  if (op_done) h <= div_quo;
        ST_SQRT:  if (op_done) sq <= div_quo[32:0];
        ST_XMUL: begin
          if (op_done) begin
            xq   <= x_clip[31:2];
            acc  <= ONE28;
            kcnt <= 5'(EXP_TERMS);
          end
        end
        ST_EMUL: if (op_done) t <= {28'd0, mul_prod[63:28]};
        ST_EDIV: begin
          if (op_done) begin
            acc  <= acc_new;
            kcnt <= kcnt - 5'd1;
            if (kcnt == 5'd1) up_factor <= (acc_new > M32) ? M32[31:0] : acc_new[31:0];
          end
        end
        ST_DDIV:  if (op_done) d <= div_quo[31:0];
        ST_RMUL1: if (op_done) rh1 <= mul_prod[63:0];
        ST_RMUL2: begin
          if (op_done) growth_factor <= (rr_full > M32) ? M32[31:0] : rr_full[31:0];
        end
        ST_PCHK: begin
          upow_cur       <= ONE28;
          dpow_cur       <= ONE28;
          icnt           <= AW'(1);
          up_probability <= (growth_factor <= d) ? '0 : ONE30[30:0];
        end
        ST_PDIV:  if (op_done) up_probability <= div_quo[30:0];
        ST_PWR_U: if (op_done) upow_cur <= sat28_64(mul_prod);
        ST_PWR_D: begin
          if (op_done) begin
            dpow_cur <= mul_prod[91:28];
            if (icnt == n) begin
              icnt <= '0;
              leaf <= 1'b1;
            end else begin
              icnt <= icnt + 1'b1;
            end
          end
        end
        ST_NP_RD: ;
        ST_NP_MUL1: if (op_done) t <= sat28_64(mul_prod);
        ST_NP_MUL2: begin
          if (op_done) begin
            if (leaf) begin
              if (icnt == n) leaf <= 1'b0;
              else           icnt <= icnt + 1'b1;
            end else if (last_j) begin
              icnt <= icnt - 1'b1;
              jcnt <= '0;
            end else begin
              jcnt <= jcnt + 1'b1;
            end
          end
        end
        ST_LVL_MUL: if (op_done) q <= mul_prod[63:0];
        ST_LVL_DIV: begin
          if (op_done) begin
            base <= (33'(s_reg) > dvx) ? 32'(33'(s_reg) - dvx) : '0;
            jcnt <= '0;
          end
        end
        ST_ND_RD1: ;
        ST_ND_RD2: vup <= node_rd;
        ST_ND_RD3: vdn <= node_rd;
        ST_ND_MUL1: if (op_done) a1 <= mul_prod[63:0];
        ST_ND_MUL2: if (op_done) t <= a1 + mul_prod[63:0];
        ST_ND_DIV: begin
          if (op_done) begin
            v <= div_quo;
            if (!mode[1]) begin
              if (last_j) begin
                icnt <= icnt - 1'b1;
                jcnt <= '0;
              end else begin
                jcnt <= jcnt + 1'b1;
              end
            end
          end
        end
        ST_OUT_RD: ;
        ST_OUT_CAP: begin
          option_value <= node_rd;
          periods_used <= 11'(n);
          date_error   <= 1'b0;
          done         <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign busy = state != ST_IDLE;

endmodule
`default_nettype wire
